// ----- hdl/lphs_pkg.sv -----
// ============================================================================
// lphs_pkg
// Shared types and constants for the linear-probing hash set: hash constants,
// opcodes, controller states and the command/status bundles between the
// controller and the datapath.
// ============================================================================
`default_nettype none

package lphs_pkg;

    // Key half width and width of the reported entry count.
    localparam int KEY_W   = 64;
    localparam int COUNT_W = 11;

    // Hash constants of the splitmix64 finalizer.
    localparam logic [KEY_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [KEY_W-1:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_C2     = 64'h94d049bb133111eb;
    localparam int ROT_HI   = 23;
    localparam int SHIFT_M1 = 30;
    localparam int SHIFT_M2 = 27;
    localparam int SHIFT_F  = 31;

    // Operation carried by an input word.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_FIN,
        S_HOME,
        S_READ,
        S_CMP
    } t_state;

    // Partial product taken in one multiply step (low 64 bits of a 64x64 product).
    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_HI_LO,
        MUL_LO_HI
    } t_mul_step;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      clr_wr;
        logic      load;
        logic      mul_en;
        t_mul_step mul_step;
        logic      mul_round;
        logic      fin;
        logic      home_step;
        logic      rd;
        logic      next;
        logic      ins;
        logic      post;
        logic      post_found;
        logic      post_ins;
        logic      post_full;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_insert;
        logic slot_free;
        logic key_match;
        logic sweep_last;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/linear_probe_hash_set_top.sv -----
// ============================================================================
// linear_probe_hash_set_top
// Set of 128-bit keys in an open-addressing table with linear probing.
// ============================================================================
// Each input word inserts a key or looks one up and gives exactly one result
// word carrying found, inserted, table_full and the entry count after the
// operation. SLOTS must be a power of two: the home slot is the hash masked to
// the table size. After reset the block sweeps the table once to mark every
// slot free, one slot per cycle, stalling its input until the sweep ends.
// An item then runs the two 64-bit mixing multiplies, three partial products
// each on one shared 32x32 multiplier, finishes the hash, loads the home
// slot, and for each probe reads the slot memory and then compares. The next
// word can be accepted in the cycle after the result is posted; a result is
// posted only while the output register holds no stalled result.
// An insert into a full table stops after one sweep of SLOTS probes and
// reports table_full.
// The block handles one item at a time; a finished result may wait in the
// output register while the next word is accepted.
`default_nettype none

module linear_probe_hash_set_top #(
    parameter int SLOTS = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_opcode,
    input  wire  [lphs_pkg::KEY_W-1:0]   i_key_low,
    input  wire  [lphs_pkg::KEY_W-1:0]   i_key_high,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_found,
    output logic                         o_inserted,
    output logic                         o_table_full,
    output logic [lphs_pkg::COUNT_W-1:0] o_entry_count
);

    lphs_pkg::t_dp_cmd    w_cmd;
    lphs_pkg::t_dp_status w_status;

    lphs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    lphs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_opcode      (i_opcode),
        .i_key_low     (i_key_low),
        .i_key_high    (i_key_high),
        .i_out_stall   (i_stall),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_inserted    (o_inserted),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

// ----- hdl/lphs_ctrl.sv -----
// ============================================================================
// lphs_ctrl
// Controller state machine: clearing pass after reset, word acceptance, hash
// sequencing, and the probe loop with its result decision.
// ============================================================================
`default_nettype none

module lphs_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire lphs_pkg::t_dp_status i_status,
    output lphs_pkg::t_dp_cmd         o_cmd
);

    lphs_pkg::t_state    r_state, n_state;
    lphs_pkg::t_mul_step r_step, n_step;
    logic                r_round, n_round;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lphs_pkg::S_CLEAR;
            r_step  <= lphs_pkg::MUL_LO_LO;
            r_round <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_round <= n_round;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_round         = r_round;
        o_stall         = 1'b1;
        o_cmd           = '0;
        o_cmd.mul_step  = r_step;
        o_cmd.mul_round = r_round;

        unique case (r_state)
            // Sweep the table once, marking every slot free.
            lphs_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = lphs_pkg::S_IDLE;
                end
            end

            lphs_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = lphs_pkg::MUL_LO_LO;
                    n_round    = 1'b0;
                    n_state    = lphs_pkg::S_MUL;
                end
            end

            // Two mixing rounds, three partial products each.
            lphs_pkg::S_MUL: begin
                o_cmd.mul_en = 1'b1;
                unique case (r_step)
                    lphs_pkg::MUL_LO_LO: n_step = lphs_pkg::MUL_HI_LO;
                    lphs_pkg::MUL_HI_LO: n_step = lphs_pkg::MUL_LO_HI;
                    lphs_pkg::MUL_LO_HI: begin
                        n_step = lphs_pkg::MUL_LO_LO;
                        if (r_round) begin
                            n_state = lphs_pkg::S_FIN;
                        end else begin
                            n_round = 1'b1;
                        end
                    end
                    default: n_step = lphs_pkg::MUL_LO_LO;
                endcase
            end

            lphs_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = lphs_pkg::S_HOME;
            end

            // Load the home slot and start the probe count.
            lphs_pkg::S_HOME: begin
                o_cmd.home_step = 1'b1;
                n_state         = lphs_pkg::S_READ;
            end

            lphs_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = lphs_pkg::S_CMP;
            end

            // A free slot, a match or a full sweep ends the probe.
            lphs_pkg::S_CMP: begin
                priority if (i_status.slot_free || i_status.key_match ||
                             i_status.sweep_last) begin
                    if (!i_status.out_busy) begin
                        o_cmd.post       = 1'b1;
                        o_cmd.post_found = i_status.key_match;
                        o_cmd.post_ins   = i_status.slot_free && i_status.is_insert;
                        o_cmd.post_full  = !i_status.slot_free && !i_status.key_match &&
                                           i_status.is_insert;
                        o_cmd.ins        = i_status.slot_free && i_status.is_insert;
                        n_state          = lphs_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = lphs_pkg::S_READ;
                end
            end

            default: n_state = lphs_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lphs_dp.sv -----
// ============================================================================
// lphs_dp
// Datapath: key registers, the splitmix64 hash on one shared 32x32
// multiplier, home slot selection, the slot memory and the output register.
// ============================================================================
`default_nettype none

module lphs_dp #(
    parameter int SLOTS = 1024
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire lphs_pkg::t_dp_cmd          i_cmd,
    output lphs_pkg::t_dp_status            o_status,
    input  wire                             i_opcode,
    input  wire  [lphs_pkg::KEY_W-1:0]      i_key_low,
    input  wire  [lphs_pkg::KEY_W-1:0]      i_key_high,
    input  wire                             i_out_stall,
    output logic                            o_valid,
    output logic                            o_found,
    output logic                            o_inserted,
    output logic                            o_table_full,
    output logic [lphs_pkg::COUNT_W-1:0]    o_entry_count
);

    localparam int KW = lphs_pkg::KEY_W;
    localparam int HW = KW / 2;
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = 2 * KW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    // Slot memory: {occupied, key high, key low}.
    logic [MW-1:0] r_mem [SLOTS];

    lphs_pkg::t_opcode r_op;
    logic [KW-1:0]     r_key_lo, r_key_hi;
    logic [KW-1:0]     r_v, r_acc;
    logic [AW-1:0]     r_h, r_pos, r_probes, r_clr;
    logic              r_rd_occ;
    logic [KW-1:0]     r_rd_lo, r_rd_hi;
    logic [CW-1:0]     r_count;
    logic              r_ovalid, r_ofound, r_oins, r_ofull;
    logic [lphs_pkg::COUNT_W-1:0] r_ocount;

    logic [KW-1:0] w_rot, w_x, w_c, w_prod;
    logic [HW-1:0] w_ma, w_mb;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [MW-1:0] w_wdata;
    logic [CW-1:0] w_count_inc;

    // Mix input for the current round and the multiplier operands.
    assign w_rot = {i_key_high[KW-1-lphs_pkg::ROT_HI:0],
                    i_key_high[KW-1:KW-lphs_pkg::ROT_HI]};
    assign w_x   = i_cmd.mul_round ? (r_v ^ (r_v >> lphs_pkg::SHIFT_M2))
                                   : (r_v ^ (r_v >> lphs_pkg::SHIFT_M1));
    assign w_c   = i_cmd.mul_round ? lphs_pkg::MIX_C2 : lphs_pkg::MIX_C1;

    always_comb begin
        unique case (i_cmd.mul_step)
            lphs_pkg::MUL_LO_LO: begin
                w_ma = w_x[HW-1:0];
                w_mb = w_c[HW-1:0];
            end
            lphs_pkg::MUL_HI_LO: begin
                w_ma = w_x[KW-1:HW];
                w_mb = w_c[HW-1:0];
            end
            lphs_pkg::MUL_LO_HI: begin
                w_ma = w_x[HW-1:0];
                w_mb = w_c[KW-1:HW];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = KW'(w_ma) * KW'(w_mb);

    // Hash and probe registers. The table size is a power of two, so the
    // home slot is the low bits of the finished hash.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= lphs_pkg::t_opcode'(i_opcode);
            r_key_lo <= i_key_low;
            r_key_hi <= i_key_high;
            r_v      <= (i_key_low ^ w_rot) + lphs_pkg::GOLDEN_INC;
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_step)
                lphs_pkg::MUL_LO_LO: r_acc <= w_prod;
                lphs_pkg::MUL_HI_LO: r_acc[KW-1:HW] <= r_acc[KW-1:HW] + w_prod[HW-1:0];
                lphs_pkg::MUL_LO_HI: r_v <= {r_acc[KW-1:HW] + w_prod[HW-1:0],
                                             r_acc[HW-1:0]};
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.fin) begin
            r_h <= AW'(r_v ^ (r_v >> lphs_pkg::SHIFT_F));
        end
        if (i_cmd.home_step) begin
            r_probes <= '0;
            r_pos    <= r_h;
        end
        if (i_cmd.next) begin
            r_pos    <= (r_pos == LAST_SLOT) ? '0 : r_pos + AW'(1);
            r_probes <= r_probes + AW'(1);
        end
    end

    // Memory write port: clearing pass or insertion.
    assign w_we    = i_cmd.clr_wr || i_cmd.ins;
    assign w_waddr = i_cmd.clr_wr ? r_clr : r_pos;
    assign w_wdata = i_cmd.clr_wr ? MW'(0) : {1'b1, r_key_hi, r_key_lo};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            {r_rd_occ, r_rd_hi, r_rd_lo} <= r_mem[r_pos];
        end
    end

    // Clear address, entry count and output register.
    assign w_count_inc = r_count + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.ins) begin
                r_count <= w_count_inc;
            end
            if (i_cmd.post) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_ofound <= i_cmd.post_found;
            r_oins   <= i_cmd.post_ins;
            r_ofull  <= i_cmd.post_full;
            r_ocount <= i_cmd.post_ins ? lphs_pkg::COUNT_W'(w_count_inc)
                                       : lphs_pkg::COUNT_W'(r_count);
        end
    end

    // Status toward the controller.
    assign o_status.clr_last   = (r_clr == LAST_SLOT);
    assign o_status.is_insert  = (r_op == lphs_pkg::OP_INSERT);
    assign o_status.slot_free  = !r_rd_occ;
    assign o_status.key_match  = r_rd_occ && (r_rd_lo == r_key_lo) && (r_rd_hi == r_key_hi);
    assign o_status.sweep_last = (r_probes == LAST_SLOT);
    assign o_status.out_busy   = r_ovalid && i_out_stall;

    assign o_valid       = r_ovalid;
    assign o_found       = r_ofound;
    assign o_inserted    = r_oins;
    assign o_table_full  = r_ofull;
    assign o_entry_count = r_ocount;

endmodule

`default_nettype wire

// ----- hdl/lphs_chk.sv -----
// ============================================================================
// lphs_chk
// Port-level checker for the hash set, bound to the top level.
// ============================================================================
`default_nettype none

module lphs_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          o_stall,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire                          o_found,
    input wire                          o_inserted,
    input wire                          o_table_full,
    input wire [lphs_pkg::COUNT_W-1:0]  o_entry_count
);

    // Reset starts the clearing pass with no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_stall && !o_valid))
        else $error("reset did not stall input and drop output valid");

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found) && $stable(o_inserted) &&
                                  $stable(o_table_full) && $stable(o_entry_count)))
        else $error("stalled result word changed");

    // At most one outcome flag per result.
    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_found, o_inserted, o_table_full}) <= 1))
        else $error("result word carries conflicting outcome flags");

    // One item at a time: an accepted word stalls the input next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while an item was in progress");

endmodule

bind linear_probe_hash_set_top lphs_chk u_lphs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_found       (o_found),
    .o_inserted    (o_inserted),
    .o_table_full  (o_table_full),
    .o_entry_count (o_entry_count)
);

`default_nettype wire
